/* sv/sha_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and a rotate helper for the stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last;
	} out_beat_t;

	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic       wr_byte;
		logic [7:0] wr_data;
		logic       count_byte;
		logic       load;
		logic       round;
		logic       fold;
		logic       reinit;
		logic [5:0] rnd;
		logic [2:0] out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
		logic [7:0] len_byte;
	} dp_stat_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		ror32 = (x >> n) | (x << (32 - n));
	endfunction

endpackage

`default_nettype wire

/* sv/sha_datapath.sv */
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Schedule window (which also collects the block bytes), working variables,
// hash words and message length.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_pkg::dp_cmd_t  cmd,
	output sha_pkg::dp_stat_t      stat,
	output logic [31:0]            word_out
);
	import sha_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  fill_q;
	logic [63:0] bytes_q;

	logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;
	logic [63:0] bits;

	always_comb begin
		s1 = ror32(w_q[14], 17) ^ ror32(w_q[14], 19) ^ (w_q[14] >> 10);
		s0 = ror32(w_q[1], 7) ^ ror32(w_q[1], 18) ^ (w_q[1] >> 3);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = (cmd.rnd < 6'd16) ? w_q[0] : w_new;
		e = v_q[4];
		a = v_q[0];
		t1 = v_q[7] + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) +
			((e & v_q[5]) ^ (~e & v_q[6])) + ROUND_K[cmd.rnd] + w_cur;
		t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) +
			((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		bits = {bytes_q[60:0], 3'b000};
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			case (fill_q[1:0])
				2'd0: w_q[fill_q[5:2]][31:24] <= cmd.wr_data;
				2'd1: w_q[fill_q[5:2]][23:16] <= cmd.wr_data;
				2'd2: w_q[fill_q[5:2]][15:8]  <= cmd.wr_data;
				default: w_q[fill_q[5:2]][7:0] <= cmd.wr_data;
			endcase
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			bytes_q <= '0;
			h_q     <= INIT_H;
			v_q     <= INIT_H;
		end else begin
			if (cmd.wr_byte) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.count_byte) begin
				bytes_q <= bytes_q + 64'd1;
			end
			if (cmd.load) begin
				v_q <= h_q;
			end else if (cmd.round) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (cmd.reinit) begin
				h_q     <= INIT_H;
				bytes_q <= '0;
				fill_q  <= '0;
			end
		end
	end

	always_comb begin
		stat.fill     = fill_q;
		stat.len_byte = bits[8*(7 - (fill_q[2:0])) +: 8];
		word_out      = h_q[cmd.out_sel];
	end

endmodule

`default_nettype wire

/* sv/sha_ctrl.sv */
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences absorption, padding, rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::in_beat_t  in_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              out_idx,
	output sha_pkg::dp_cmd_t        cmd,
	input  wire sha_pkg::dp_stat_t  stat
);
	import sha_pkg::*;

	ctl_state_t state_q, state_d;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q, len_ok_q;
	logic       full;

	assign full = (stat.fill == 6'd63);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.operation == OP_FINISH) begin
						state_d = full ? ST_ROUND : ST_PAD;
					end else if (full) begin
						state_d = ST_ROUND;
					end
				end
			end
			ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
			ST_FOLD: begin
				if (!fin_q) begin
					state_d = ST_IDLE;
				end else if (len_ok_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (full) begin
					state_d = ST_ROUND;
				end
			end
			ST_EMIT: if (!out_stall && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.out_sel = idx_q;
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_EMIT);
		out_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.wr_byte = 1'b1;
					cmd.load = full;
					if (in_data.operation == OP_FINISH) begin
						cmd.wr_data = PAD_MARK;
					end else begin
						cmd.wr_data = in_data.data_byte;
						cmd.count_byte = 1'b1;
					end
				end
			end
			ST_ROUND: cmd.round = 1'b1;
			ST_FOLD:  cmd.fold = 1'b1;
			ST_PAD: begin
				cmd.wr_byte = 1'b1;
				cmd.load = full;
				cmd.wr_data = (len_ok_q && stat.fill >= LEN_POS) ? stat.len_byte : 8'h00;
			end
			ST_EMIT: cmd.reinit = !out_stall && idx_q == 3'd7;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rnd_q    <= '0;
			idx_q    <= '0;
			fin_q    <= 1'b0;
			len_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_IDLE && in_valid && in_data.operation == OP_FINISH) begin
				fin_q    <= 1'b1;
				len_ok_q <= (stat.fill < LEN_POS);
			end
			if (state_q == ST_FOLD && fin_q && !len_ok_q) begin
				len_ok_q <= 1'b1;
			end
			if (state_q == ST_EMIT && !out_stall) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					fin_q    <= 1'b0;
					len_ok_q <= 1'b0;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> !cmd.wr_byte) else $error("write during rounds");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during output");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> idx_q == 3'd0) else $error("digest not from word 0");

endmodule

`default_nettype wire

/* sv/sha256_stream_hasher.sv */
// An absorb beat writes one byte; one that fills a block then stalls the input through the rounds and fold.
// A finish beat pads one byte a cycle, runs the rounds and fold for each final block
// (one or two), then gives eight output beats, one per cycle without stall.
// Throughput is set by the one-round-per-cycle compression, during which the input stalls.
// Asynchronous active-low reset restores initial hash values and clears counts.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 engine with a controller and a datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sha_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sha_pkg::out_beat_t      out_data
);
	import sha_pkg::*;

	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic [31:0] word;
	logic [2:0]  idx;

	sha_ctrl u_ctrl (
		.clk, .arst_n, .in_data, .in_valid, .in_stall,
		.out_valid, .out_stall, .out_idx(idx), .cmd, .stat
	);

	sha_datapath u_dp (
		.clk, .arst_n, .cmd, .stat, .word_out(word)
	);

	always_comb begin
		out_data.digest_word = word;
		out_data.word_index  = idx;
		out_data.last        = (idx == 3'd7);
	end

endmodule

`default_nettype wire
